[rtl/sprite_rle_line_decoder_core_assert.svh]
// ---------------------------------------------------------------------------
// Sprite RLE decoder assertion macros
// Shared property wrappers for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef SPRITE_RLE_LINE_DECODER_CORE_ASSERT_SVH
`define SPRITE_RLE_LINE_DECODER_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SRLD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srld assertion failed");

// next-cycle implication, disabled while in reset
`define SRLD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srld assertion failed");

`endif

[rtl/srld_pkg.sv]
// ---------------------------------------------------------------------------
// srld_pkg
// Shared types and constants of the sprite RLE line decoder.
// ---------------------------------------------------------------------------
package srld_pkg;

  localparam int CFG_W  = 12;  // frame_height / frame_width
  localparam int CODE_W = 8;
  localparam int ADDR_W = 1;

  localparam logic [ADDR_W-1:0] REG_FRAME_HEIGHT = 1'b0;
  localparam logic [ADDR_W-1:0] REG_FRAME_WIDTH  = 1'b1;

  localparam logic [CODE_W-1:0] CTRL_EOL  = 8'h80;
  localparam logic [6:0]        CTRL_LOW  = 7'h7F;

  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd1;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd1;

  typedef struct packed {
    logic [CODE_W-1:0] code_byte;
    logic              frame_start;
  } srld_item_t;

endpackage

[rtl/srld_in_reg.sv]
// ---------------------------------------------------------------------------
// srld_in_reg
// Input register slice: holds one code byte until the decoder consumes it.
// ---------------------------------------------------------------------------
module srld_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  srld_pkg::srld_item_t in_item,
  input  logic                take,
  output logic                item_valid,
  output srld_pkg::srld_item_t item
);
  import srld_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  srld_item_t item_r;

  // refill in the same cycle the held beat is consumed
  assign in_tready  = !valid_r || take;
  assign valid_nxt  = (in_tvalid && in_tready) || (valid_r && !take);
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

endmodule

[rtl/srld_decode.sv]
// ---------------------------------------------------------------------------
// srld_decode
// Frame registers, cursor state and the per-byte decode step.
// ---------------------------------------------------------------------------
module srld_decode #(
  parameter int COORD_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [srld_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [srld_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        item_valid,
  input  srld_pkg::srld_item_t        item,
  input  logic                        slot_free,
  output logic                        take,
  output logic                        res_valid,
  output logic [COORD_BITS-1:0]       res_x,
  output logic [COORD_BITS:0]         res_y,
  output logic [srld_pkg::CODE_W-1:0] res_color,
  output logic                        res_inside
);
  import srld_pkg::*;

  localparam int CMP_W = ((COORD_BITS > CFG_W) ? COORD_BITS : CFG_W) + 1;
  localparam logic [CMP_W-1:0] COORD_MAX_C = CMP_W'((1 << COORD_BITS) - 1);

  logic [CFG_W-1:0]      frame_height_r;
  logic [CFG_W-1:0]      frame_width_r;
  logic [6:0]            literal_left_r, literal_left_nxt;
  logic [COORD_BITS-1:0] cursor_x_r, cursor_x_nxt;
  logic [COORD_BITS:0]   cursor_y_r, cursor_y_nxt;

  logic [6:0]            lit_w;
  logic [COORD_BITS-1:0] x_w;
  logic [COORD_BITS:0]   y_w;
  logic [COORD_BITS:0]   start_y;
  logic [CFG_W-1:0]      h_m1;
  logic [COORD_BITS:0]   x_sum;
  logic [COORD_BITS-1:0] x_sat;
  logic                  produce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_height_r <= FRAME_HEIGHT_RST;
      frame_width_r  <= FRAME_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // first row of a frame: height-1, -1 for zero height, clamped to the top
  always_comb begin
    h_m1 = frame_height_r - 1'b1;
    if (frame_height_r == '0) begin
      start_y = '1;
    end else if (CMP_W'(h_m1) > COORD_MAX_C) begin
      start_y = {1'b0, {COORD_BITS{1'b1}}};
    end else begin
      start_y = (COORD_BITS + 1)'(CMP_W'(h_m1));
    end
  end

  always_comb begin
    lit_w = literal_left_r;
    x_w   = cursor_x_r;
    y_w   = cursor_y_r;
    if (item.frame_start) begin
      lit_w = '0;
      x_w   = '0;
      y_w   = start_y;
    end

    produce = (lit_w != '0);
    // literal advance is +1, skip is +low7; both saturate at the top column
    x_sum = {1'b0, x_w} + (produce ? (COORD_BITS + 1)'(1)
                                   : (COORD_BITS + 1)'(item.code_byte[6:0] & CTRL_LOW));
    x_sat = x_sum[COORD_BITS] ? {COORD_BITS{1'b1}} : x_sum[COORD_BITS-1:0];

    literal_left_nxt = lit_w;
    cursor_x_nxt     = x_w;
    cursor_y_nxt     = y_w;
    if (produce) begin
      literal_left_nxt = lit_w - 1'b1;
      cursor_x_nxt     = x_sat;
    end else if (item.code_byte == CTRL_EOL) begin
      cursor_x_nxt = '0;
      if (!y_w[COORD_BITS]) begin
        cursor_y_nxt = y_w - 1'b1;
      end
    end else if (item.code_byte[CODE_W-1]) begin
      cursor_x_nxt = x_sat;
    end else begin
      literal_left_nxt = item.code_byte[6:0];
    end
  end

  assign take       = item_valid && slot_free;
  assign res_valid  = take && produce;
  assign res_x      = x_w;
  assign res_y      = y_w;
  assign res_color  = item.code_byte;
  assign res_inside = (CMP_W'(x_w) < CMP_W'(frame_width_r)) && !y_w[COORD_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      literal_left_r <= '0;
      cursor_x_r     <= '0;
      cursor_y_r     <= '0;
    end else if (take) begin
      literal_left_r <= literal_left_nxt;
      cursor_x_r     <= cursor_x_nxt;
      cursor_y_r     <= cursor_y_nxt;
    end
  end

endmodule

[rtl/srld_out_reg.sv]
// ---------------------------------------------------------------------------
// srld_out_reg
// Result register: packs one pixel write and holds it until taken.
// ---------------------------------------------------------------------------
module srld_out_reg #(
  parameter int COORD_BITS = 12,
  parameter int DATA_W     = 40
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        res_valid,
  input  logic [COORD_BITS-1:0]       res_x,
  input  logic [COORD_BITS:0]         res_y,
  input  logic [srld_pkg::CODE_W-1:0] res_color,
  input  logic                        res_inside,
  output logic                        slot_free,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [DATA_W-1:0]           out_tdata,
  output logic                        out_tuser
);
  import srld_pkg::*;

  logic              valid_r;
  logic [DATA_W-1:0] data_r;
  logic              user_r;

  assign slot_free  = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (slot_free) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && res_valid) begin
      data_r <= DATA_W'({res_color, res_y, res_x});
      user_r <= res_inside;
    end
  end

endmodule

[rtl/sprite_rle_line_decoder_core.sv]
// ---------------------------------------------------------------------------
// sprite_rle_line_decoder_core
// Run-length sprite line decoder: code bytes in, pixel writes out.
// ---------------------------------------------------------------------------
// Takes one code byte per clock and decodes it in a single registered pass
// (input register, decode logic, result register), so a byte can be accepted
// every cycle; a literal byte passes the input register and then the result
// register before its pixel write shows on out_tvalid.
// Throughput is one byte per cycle, set by the single decode step that
// updates the cursor; it drops only while out_tready holds a result back.
// A beat with in_tuser set starts a frame at x=0, y=frame_height-1. Only
// literal bytes produce an output beat; control bytes are consumed silently.
// Registers (cfg_addr): 0 frame_height, 1 frame_width; write only while idle.
// ---------------------------------------------------------------------------
module sprite_rle_line_decoder_core #(
  parameter int COORD_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [srld_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [srld_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] code_byte
  input  logic                        in_tuser,   // [0] frame_start
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // pixel_x, pixel_y (signed), color, zero fill to whole bytes
  output logic [((2*COORD_BITS+9+7)/8)*8-1:0] out_tdata,
  output logic                        out_tuser   // [0] inside_res
);
  import srld_pkg::*;

  localparam int OUT_DATA_W = ((2 * COORD_BITS + 9 + 7) / 8) * 8;

  srld_item_t            in_item;
  srld_item_t            item;
  logic                  item_valid;
  logic                  take;
  logic                  slot_free;
  logic                  res_valid;
  logic [COORD_BITS-1:0] res_x;
  logic [COORD_BITS:0]   res_y;
  logic [CODE_W-1:0]     res_color;
  logic                  res_inside;

  assign in_item.code_byte   = in_tdata;
  assign in_item.frame_start = in_tuser;

  srld_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  srld_decode #(
    .COORD_BITS (COORD_BITS)
  ) u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .slot_free  (slot_free),
    .take       (take),
    .res_valid  (res_valid),
    .res_x      (res_x),
    .res_y      (res_y),
    .res_color  (res_color),
    .res_inside (res_inside)
  );

  srld_out_reg #(
    .COORD_BITS (COORD_BITS),
    .DATA_W     (OUT_DATA_W)
  ) u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_x      (res_x),
    .res_y      (res_y),
    .res_color  (res_color),
    .res_inside (res_inside),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[rtl/srld_checker.sv]
// ---------------------------------------------------------------------------
// srld_checker
// Port-level checks of the sprite RLE line decoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "sprite_rle_line_decoder_core_assert.svh"

module srld_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_tvalid,
  input logic                                   in_tready,
  input logic                                   out_tvalid,
  input logic                                   out_tready,
  input logic [((2*COORD_BITS+9+7)/8)*8-1:0]    out_tdata,
  input logic                                   out_tuser
);

  // stalled result must hold
  `SRLD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // a pixel flagged inside never sits on a negative row
  `SRLD_ASSERT_NOW(a_inside_row, out_tvalid && out_tuser, !out_tdata[2*COORD_BITS])

  // with the result slot empty the input side never stalls
  `SRLD_ASSERT_NOW(a_no_bubble, !out_tvalid, in_tready)

  // an idle input with an empty result slot leaves the input slot empty and ready
  `SRLD_ASSERT_NEXT(a_fill_on_stall, !in_tvalid && !out_tvalid, in_tready)

endmodule

bind sprite_rle_line_decoder_core srld_checker #(
  .COORD_BITS (COORD_BITS)
) u_srld_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
